/* src/pts_pkg.sv */
// Package for the priority thread scheduler.
// Holds opcodes, thread states, status codes, controller states and fixed field widths.
// Depends on nothing; every other file of the block uses it.
package pts_pkg;

  localparam int OPCODE_W = 3;
  localparam int ID_W     = 4;
  localparam int PRIO_W   = 3;
  localparam int STATUS_W = 2;
  localparam int BURST_W  = 4;

  localparam logic [BURST_W-1:0] BURST_RESET = 4'd4;

  typedef enum logic [OPCODE_W-1:0] {
    OP_START    = 3'd0,
    OP_READY    = 3'd1,
    OP_PREEMPT  = 3'd2,
    OP_WAIT     = 3'd3,
    OP_SCHEDULE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_UNUSED  = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_WAITING = 2'd3
  } thread_state_t;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TREAD,
    S_SCAN,
    S_FALLBACK,
    S_POP,
    S_RUN,
    S_DONE
  } fsm_t;

endpackage

/* src/pts_ifs.sv */
// Valid/ready channel interfaces for scheduler requests and responses.
// Depends on pts_pkg for the field widths.
interface pts_req_if;
  logic                          valid;
  logic                          ready;
  logic [pts_pkg::OPCODE_W-1:0]  opcode;
  logic [pts_pkg::ID_W-1:0]      thread_id;
  logic [pts_pkg::PRIO_W-1:0]    priority_req;

  modport source (output valid, opcode, thread_id, priority_req, input ready);
  modport sink (input valid, opcode, thread_id, priority_req, output ready);
endinterface

interface pts_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pts_pkg::STATUS_W-1:0]  status;
  logic [pts_pkg::ID_W-1:0]      chosen_thread;

  modport source (output valid, status, chosen_thread, input ready);
  modport sink (input valid, status, chosen_thread, output ready);
endinterface

/* src/pts_thread_table.sv */
// Per-thread state and priority table: a synchronous memory with a registered read port.
// Valid bits make never-written entries read as unused with priority zero.
// Depends on pts_pkg for the thread state type.
module pts_thread_table #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int PW    = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output pts_pkg::thread_state_t rd_state,
  output logic [PW-1:0]          rd_prio,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  pts_pkg::thread_state_t wr_state,
  input  logic [PW-1:0]          wr_prio
);

  logic [PW+1:0]  mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [PW+1:0]  rd_data;
  logic           rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_state, wr_prio};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_state = rd_valid ? pts_pkg::thread_state_t'(rd_data[PW+1:PW]) : pts_pkg::ST_UNUSED;
  assign rd_prio  = rd_valid ? rd_data[PW-1:0] : '0;

endmodule

/* src/priority_thread_scheduler.sv */
// Channel | Dir | Fields                                  | Transfer when
// req     | in  | opcode, thread_id, priority_req          | req.valid && req.ready
// rsp     | out | status, chosen_thread                    | rsp.valid && rsp.ready
// cfg     | in  | cfg_wdata (burst_limit)                  | cfg_we
// One request is in flight at a time. Start, ready, preempt and wait load their response
// in S_TREAD, once the registered thread table read has returned the thread's entry.
// Schedule scans the levels from LEVEL_COUNT - 1 down to 0, one priority level examined per cycle.
// Reset (rst, synchronous) empties all queues, marks all threads unused and sets
// burst_limit to 4. A waiting response holds the next request in the done state only.
// Depends on pts_pkg, pts_ifs and pts_thread_table.
module priority_thread_scheduler #(
  parameter int THREAD_COUNT = 16,
  parameter int LEVEL_COUNT  = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [pts_pkg::BURST_W-1:0]  cfg_wdata,
  pts_req_if.sink                      req,
  pts_rsp_if.source                    rsp
);

  localparam int TW = $clog2(THREAD_COUNT);
  localparam int LW = $clog2(LEVEL_COUNT);
  localparam int CW = $clog2(THREAD_COUNT + 1);

  pts_pkg::fsm_t state, state_next;

  logic [pts_pkg::OPCODE_W-1:0] op;
  logic [pts_pkg::ID_W-1:0]     tid;
  logic [pts_pkg::PRIO_W-1:0]   pri;
  logic [pts_pkg::BURST_W-1:0]  burst_limit;

  logic [TW-1:0]               level_head  [LEVEL_COUNT];
  logic [TW-1:0]               level_tail  [LEVEL_COUNT];
  logic [CW-1:0]               level_count [LEVEL_COUNT];
  logic [pts_pkg::BURST_W-1:0] level_burst [LEVEL_COUNT];

  logic [TW-1:0] fifo_mem [LEVEL_COUNT][THREAD_COUNT];
  logic [TW-1:0] fifo_q;

  logic [LW-1:0] scan_lvl, full_lvl, full_lvl_next;
  logic          have_full, have_full_next;

  logic [pts_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic [pts_pkg::ID_W-1:0]     res_chosen, res_chosen_next;
  logic                         res_load;

  logic [LW-1:0]               lvl_rd;
  logic [TW-1:0]               head_cur, tail_cur;
  logic [CW-1:0]               cnt_cur;
  logic [pts_pkg::BURST_W-1:0] burst_cur;
  logic                        q_full;

  logic push_en, pop_en, scan_hit, scan_zero, fallback, clear_all;
  logic id_ok, pri_ok;

  logic                   tt_rd_en, tt_we;
  logic [TW-1:0]          tt_rd_addr, tt_waddr;
  pts_pkg::thread_state_t t_state, tt_wstate;
  logic [LW-1:0]          t_prio, tt_wprio;

  pts_thread_table #(
    .DEPTH (THREAD_COUNT),
    .AW    (TW),
    .PW    (LW)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (tt_rd_en),
    .rd_addr  (tt_rd_addr),
    .rd_state (t_state),
    .rd_prio  (t_prio),
    .wr_en    (tt_we),
    .wr_addr  (tt_waddr),
    .wr_state (tt_wstate),
    .wr_prio  (tt_wprio)
  );

  assign id_ok  = 32'(tid) < THREAD_COUNT;
  assign pri_ok = 32'(pri) < LEVEL_COUNT;

  always_comb begin
    unique case (state)
      pts_pkg::S_TREAD:    lvl_rd = t_prio;
      pts_pkg::S_FALLBACK: lvl_rd = full_lvl;
      default:             lvl_rd = scan_lvl;
    endcase
  end

  assign head_cur  = level_head[lvl_rd];
  assign tail_cur  = level_tail[lvl_rd];
  assign cnt_cur   = level_count[lvl_rd];
  assign burst_cur = level_burst[lvl_rd];
  assign q_full    = 32'(cnt_cur) >= THREAD_COUNT;

  always_comb begin
    state_next      = state;
    req.ready       = 1'b0;
    tt_rd_en        = 1'b0;
    tt_rd_addr      = TW'(req.thread_id);
    tt_we           = 1'b0;
    tt_waddr        = TW'(tid);
    tt_wstate       = pts_pkg::ST_WAITING;
    tt_wprio        = t_prio;
    push_en         = 1'b0;
    pop_en          = 1'b0;
    scan_hit        = 1'b0;
    scan_zero       = 1'b0;
    fallback        = 1'b0;
    clear_all       = 1'b0;
    have_full_next  = have_full;
    full_lvl_next   = full_lvl;
    res_load        = 1'b0;
    res_status_next = pts_pkg::STATUS_REJECT;
    res_chosen_next = '0;
    unique case (state)
      pts_pkg::S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          tt_rd_en   = 1'b1;
          state_next = pts_pkg::S_TREAD;
        end
      end
      pts_pkg::S_TREAD: begin
        res_load   = 1'b1;
        state_next = pts_pkg::S_DONE;
        unique case (op)
          pts_pkg::OP_START: begin
            if (id_ok && pri_ok && t_state == pts_pkg::ST_UNUSED) begin
              tt_we           = 1'b1;
              tt_wstate       = pts_pkg::ST_WAITING;
              tt_wprio        = LW'(pri);
              res_status_next = pts_pkg::STATUS_OK;
            end
          end
          pts_pkg::OP_READY: begin
            if (id_ok && t_state == pts_pkg::ST_WAITING) begin
              tt_we           = 1'b1;
              tt_wstate       = pts_pkg::ST_READY;
              push_en         = 1'b1;
              res_status_next = pts_pkg::STATUS_OK;
            end
          end
          pts_pkg::OP_PREEMPT: begin
            if (id_ok) begin
              tt_we           = 1'b1;
              tt_wstate       = pts_pkg::ST_READY;
              push_en         = 1'b1;
              res_status_next = pts_pkg::STATUS_OK;
            end
          end
          pts_pkg::OP_WAIT: begin
            if (id_ok && t_state == pts_pkg::ST_RUNNING) begin
              tt_we           = 1'b1;
              tt_wstate       = pts_pkg::ST_WAITING;
              res_status_next = pts_pkg::STATUS_OK;
            end
          end
          pts_pkg::OP_SCHEDULE: begin
            res_load   = 1'b0;
            state_next = pts_pkg::S_SCAN;
          end
          default: begin
          end
        endcase
      end
      pts_pkg::S_SCAN: begin
        if (cnt_cur != '0) begin
          if (burst_cur < burst_limit) begin
            scan_hit = 1'b1;
          end else begin
            scan_zero = 1'b1;
            if (!have_full) begin
              have_full_next = 1'b1;
              full_lvl_next  = scan_lvl;
            end
          end
        end
        if (scan_hit) begin
          pop_en     = 1'b1;
          state_next = pts_pkg::S_POP;
        end else if (scan_lvl == '0) begin
          if (have_full_next) begin
            state_next = pts_pkg::S_FALLBACK;
          end else begin
            clear_all       = 1'b1;
            res_load        = 1'b1;
            res_status_next = pts_pkg::STATUS_EMPTY;
            state_next      = pts_pkg::S_DONE;
          end
        end
      end
      pts_pkg::S_FALLBACK: begin
        fallback   = 1'b1;
        pop_en     = 1'b1;
        state_next = pts_pkg::S_POP;
      end
      pts_pkg::S_POP: begin
        tt_rd_en   = 1'b1;
        tt_rd_addr = fifo_q;
        state_next = pts_pkg::S_RUN;
      end
      pts_pkg::S_RUN: begin
        tt_we           = 1'b1;
        tt_waddr        = fifo_q;
        tt_wstate       = pts_pkg::ST_RUNNING;
        res_load        = 1'b1;
        res_status_next = pts_pkg::STATUS_OK;
        res_chosen_next = pts_pkg::ID_W'(fifo_q);
        state_next      = pts_pkg::S_DONE;
      end
      pts_pkg::S_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = pts_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pts_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_limit <= pts_pkg::BURST_RESET;
    end else if (cfg_we) begin
      burst_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op  <= req.opcode;
      tid <= req.thread_id;
      pri <= req.priority_req;
    end
    if (res_load) begin
      res_status <= res_status_next;
      res_chosen <= res_chosen_next;
    end
    if (state == pts_pkg::S_DONE && state_next == pts_pkg::S_IDLE) begin
      rsp.status        <= res_status;
      rsp.chosen_thread <= res_chosen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == pts_pkg::S_DONE && state_next == pts_pkg::S_IDLE) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_lvl  <= '0;
      full_lvl  <= '0;
      have_full <= 1'b0;
    end else if (state == pts_pkg::S_TREAD) begin
      scan_lvl  <= LW'(LEVEL_COUNT - 1);
      have_full <= 1'b0;
    end else if (state == pts_pkg::S_SCAN) begin
      scan_lvl  <= scan_lvl - 1'b1;
      have_full <= have_full_next;
      full_lvl  <= full_lvl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVEL_COUNT; i++) begin
        level_head[i]  <= '0;
        level_tail[i]  <= '0;
        level_count[i] <= '0;
        level_burst[i] <= '0;
      end
    end else begin
      if (push_en && !q_full) begin
        level_tail[lvl_rd]  <= (32'(tail_cur) == THREAD_COUNT - 1) ? '0 : tail_cur + 1'b1;
        level_count[lvl_rd] <= cnt_cur + 1'b1;
      end
      if (pop_en) begin
        level_head[lvl_rd]  <= (32'(head_cur) == THREAD_COUNT - 1) ? '0 : head_cur + 1'b1;
        level_count[lvl_rd] <= cnt_cur - 1'b1;
      end
      if (clear_all) begin
        for (int i = 0; i < LEVEL_COUNT; i++) begin
          level_burst[i] <= '0;
        end
      end else if (scan_hit) begin
        level_burst[lvl_rd] <= burst_cur + 1'b1;
      end else if (scan_zero) begin
        level_burst[lvl_rd] <= '0;
      end else if (fallback) begin
        level_burst[lvl_rd] <= burst_limit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_en && !q_full) begin
      fifo_mem[lvl_rd][tail_cur] <= TW'(tid);
    end
    if (pop_en) begin
      fifo_q <= fifo_mem[lvl_rd][head_cur];
    end
  end

endmodule
